// ===== rtl/alc_pkg.sv =====
// shared types, constants and the power table of the lux calculator
package alc_pkg;

    localparam int COUNT_W = 16;
    localparam int LUX_W = 19;
    localparam int SEG_W = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [LUX_W-1:0] DARK_BOUND_RESET = 19'd25600;
    localparam logic [LUX_W-1:0] LUX_MAX = 19'd524287;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_ZERO = 3'd0;
    localparam logic [SEG_W-1:0] SEG_POWER = 3'd1;
    localparam logic [SEG_W-1:0] SEG_LIN_LOW = 3'd2;
    localparam logic [SEG_W-1:0] SEG_LIN_MID = 3'd3;
    localparam logic [SEG_W-1:0] SEG_LIN_HIGH = 3'd4;

    // power table: entry i is floor(2^16 * (i / (2 * POW_ENTRIES))^1.4)
    localparam int POW_ENTRIES = 64;
    localparam int POW_FRAC_W = 16;
    localparam int IDX_W = $clog2(POW_ENTRIES) + 1;
    localparam int QUOT_W = IDX_W + POW_FRAC_W;
    localparam int BIG_W = 192;

    // linear segment coefficients, scaled by 100000
    localparam int LIN_COEF_W = 12;
    localparam int LIN_PROD_W = COUNT_W + LIN_COEF_W;
    localparam logic [LIN_COEF_W-1:0] LIN_LOW_A = 12'd2240;
    localparam logic [LIN_COEF_W-1:0] LIN_LOW_B = 12'd3100;
    localparam logic [LIN_COEF_W-1:0] LIN_MID_A = 12'd1280;
    localparam logic [LIN_COEF_W-1:0] LIN_MID_B = 12'd1530;
    localparam logic [LIN_COEF_W-1:0] LIN_HIGH_A = 12'd146;
    localparam logic [LIN_COEF_W-1:0] LIN_HIGH_B = 12'd112;

    // power segment: coef = 304 * 2^16 - 620 * v
    localparam int COEF_W = 25;
    localparam logic [COEF_W-1:0] POW_BASE = 25'd19922944;
    localparam logic [9:0] POW_SLOPE = 10'd620;
    localparam int PROD_W = COUNT_W + COEF_W;
    localparam int PRE_SHIFT = 12;
    localparam int Z_W = PROD_W - PRE_SHIFT;

    // every path ends in floor(num / 3125), by reciprocal and one correction
    localparam int NUM_W = 31;
    localparam int DIV_W = 12;
    localparam logic [DIV_W-1:0] DIV_CONST = 12'd3125;
    localparam int RECIP_SHIFT = 43;
    localparam logic [31:0] RECIP_MULT = 32'd2814749767;
    localparam int RECIP_PROD_W = NUM_W + 32;
    localparam int QEST_W = RECIP_PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic [COUNT_W-1:0] broadband_count;
        logic [COUNT_W-1:0] infrared_count;
        logic               motion_seen;
    } alc_item_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux_value;
        logic             lux_valid;
        logic             lamp_request;
    } alc_result_t;

    typedef struct packed {
        alc_item_t        item;
        logic             lux_valid;
        logic [SEG_W-1:0] seg;
    } alc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } alc_qstat_t;

    typedef logic [POW_FRAC_W-1:0] alc_pow_table_t [0:POW_ENTRIES];

    // largest y with y^5 * (2N)^7 <= 2^80 * i^7
    function automatic logic [POW_FRAC_W-1:0] pow_entry(int unsigned idx);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        logic [POW_FRAC_W-1:0] y;
        logic [POW_FRAC_W-1:0] cand;
        rhs = BIG_W'(1) << (5 * POW_FRAC_W);
        for (int n = 0; n < 7; n++)
        begin
            rhs = rhs * BIG_W'(idx);
        end
        y = '0;
        for (int b = POW_FRAC_W - 1; b >= 0; b--)
        begin
            cand = y | (POW_FRAC_W'(1) << b);
            lhs = BIG_W'(1);
            for (int n = 0; n < 5; n++)
            begin
                lhs = lhs * BIG_W'(cand);
            end
            for (int n = 0; n < 7; n++)
            begin
                lhs = lhs * BIG_W'(2 * POW_ENTRIES);
            end
            if (lhs <= rhs)
            begin
                y = cand;
            end
        end
        return y;
    endfunction

    function automatic alc_pow_table_t build_pow_table();
        alc_pow_table_t tbl;
        for (int i = 0; i <= POW_ENTRIES; i++)
        begin
            tbl[i] = pow_entry(i);
        end
        return tbl;
    endfunction

    localparam alc_pow_table_t POW_TABLE = build_pow_table();

endpackage

// ===== rtl/alc_front.sv =====
// front end: takes a reading, sorts it into a formula segment, hands it to the queue
module alc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  alc_pkg::alc_item_t  item,
    input  alc_pkg::alc_qstat_t qstat,
    output logic                busy,
    output logic                push,
    output alc_pkg::alc_job_t   wr_job
);
    import alc_pkg::*;

    logic      in_vld_reg;
    alc_item_t in_reg;
    logic      take;

    logic [COUNT_W-1:0] c0;
    logic [COUNT_W-1:0] c1;
    logic [SEG_W-1:0]   seg;

    assign busy = in_vld_reg && qstat.full;
    assign take = start && !busy;
    assign push = in_vld_reg && !qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (push)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= item;
        end
    end

    assign c0 = in_reg.broadband_count;
    assign c1 = in_reg.infrared_count;

    // ratio bounds checked by cross multiplication
    always_comb
    begin
        if (c0 == '0)
        begin
            seg = SEG_ZERO;
        end
        else if ({c1, 1'b0} <= {1'b0, c0})
        begin
            seg = SEG_POWER;
        end
        else if (23'(c1) * 23'd100 <= 23'(c0) * 23'd61)
        begin
            seg = SEG_LIN_LOW;
        end
        else if (19'(c1) * 19'd5 <= 19'(c0) * 19'd4)
        begin
            seg = SEG_LIN_MID;
        end
        else if (20'(c1) * 20'd10 <= 20'(c0) * 20'd13)
        begin
            seg = SEG_LIN_HIGH;
        end
        else
        begin
            seg = SEG_ZERO;
        end
    end

    assign wr_job.item = in_reg;
    assign wr_job.lux_valid = (c0 != '0);
    assign wr_job.seg = seg;

endmodule

// ===== rtl/alc_queue.sv =====
// short queue of classified readings between front and back end
module alc_queue
#(
    parameter int DEPTH = alc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  alc_pkg::alc_job_t   wr_job,
    input  logic                pop,
    output alc_pkg::alc_job_t   rd_job,
    output alc_pkg::alc_qstat_t stat
);
    import alc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    alc_job_t         mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push = push && !stat.full;
    assign do_pop = pop && !stat.empty;
    assign rd_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");
`endif

endmodule

// ===== rtl/alc_back.sv =====
// back end: ratio divider, table interpolation and lux arithmetic, one reading per cycle
module alc_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  alc_pkg::alc_qstat_t         qstat,
    input  alc_pkg::alc_job_t           rd_job,
    input  logic [alc_pkg::LUX_W-1:0]   dark_bound,
    output logic                        pop,
    output logic                        done,
    output alc_pkg::alc_result_t        result
);
    import alc_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] c0;
        logic               motion;
        logic               lux_valid;
        logic [SEG_W-1:0]   seg;
        logic [NUM_W-1:0]   lin_num;
    } alc_pipe_t;

    localparam int BACK_LAT = QUOT_W + 9;

    // stage p0: linear products
    logic                  p0_vld_reg;
    alc_job_t              p0_job_reg;
    logic [LIN_PROD_W-1:0] p0_pa_reg;
    logic [LIN_PROD_W-1:0] p0_pb_reg;
    logic [LIN_COEF_W-1:0] lin_a;
    logic [LIN_COEF_W-1:0] lin_b;

    // divider stages, one quotient bit each
    logic               div_vld_reg [0:QUOT_W];
    alc_pipe_t          div_pipe_reg [0:QUOT_W];
    logic [COUNT_W-1:0] div_rem_reg [0:QUOT_W];
    logic [QUOT_W-1:0]  div_quot_reg [0:QUOT_W];
    logic [COUNT_W:0]   div_shift [1:QUOT_W];
    logic               div_ge [1:QUOT_W];
    logic [COUNT_W-1:0] div_rem_next [1:QUOT_W];
    logic [NUM_W-1:0]   lin_num_next;
    alc_pipe_t          d0_pipe_next;

    // tail stages
    logic                  e_vld_reg [1:6];
    alc_pipe_t             e_pipe_reg [1:6];
    logic [POW_FRAC_W-1:0] e1_lo_reg;
    logic [POW_FRAC_W-1:0] e1_d_reg;
    logic [POW_FRAC_W-1:0] e1_f_reg;
    logic [POW_FRAC_W-1:0] e2_v_reg;
    logic [COEF_W-1:0]     e3_coef_reg;
    logic [Z_W-1:0]        e4_z_reg;
    logic [NUM_W-1:0]      e5_n_reg;
    logic [NUM_W-1:0]      e6_n_reg;
    logic [QEST_W-1:0]     e6_qest_reg;

    logic [IDX_W-1:0]        k_raw;
    logic [IDX_W-1:0]        k_lo;
    logic [IDX_W-1:0]        k_hi;
    logic [POW_FRAC_W-1:0]   tbl_lo;
    logic [POW_FRAC_W-1:0]   tbl_hi;
    logic [POW_FRAC_W-1:0]   e1_d_next;
    logic [2*POW_FRAC_W-1:0] interp_prod;
    logic [POW_FRAC_W-1:0]   e2_v_next;
    logic [COEF_W:0]         slope_prod;
    logic [COEF_W-1:0]       e3_coef_next;
    logic [PROD_W-1:0]       lux_prod;
    logic [NUM_W-1:0]        e5_n_next;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [NUM_W+1:0]        qest_prod;
    logic [NUM_W+1:0]        rem_wide;
    logic [QEST_W:0]         quot_fix;
    logic [LUX_W-1:0]        lux_next;
    logic                    lamp_next;

    logic        done_reg;
    alc_result_t result_reg;

    // the back end never stalls, so it drains the queue every cycle
    assign pop = !qstat.empty;

    always_comb
    begin
        case (rd_job.seg)
            SEG_LIN_LOW:
            begin
                lin_a = LIN_LOW_A;
                lin_b = LIN_LOW_B;
            end
            SEG_LIN_MID:
            begin
                lin_a = LIN_MID_A;
                lin_b = LIN_MID_B;
            end
            SEG_LIN_HIGH:
            begin
                lin_a = LIN_HIGH_A;
                lin_b = LIN_HIGH_B;
            end
            default:
            begin
                lin_a = '0;
                lin_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (p0_pa_reg > p0_pb_reg)
        begin
            lin_num_next = {p0_pa_reg - p0_pb_reg, 3'b000};
        end
        else
        begin
            lin_num_next = '0;
        end
        d0_pipe_next.c0 = p0_job_reg.item.broadband_count;
        d0_pipe_next.motion = p0_job_reg.item.motion_seen;
        d0_pipe_next.lux_valid = p0_job_reg.lux_valid;
        d0_pipe_next.seg = p0_job_reg.seg;
        d0_pipe_next.lin_num = lin_num_next;
    end

    // restoring division of c1 * 2^QUOT_W by c0; c1 < c0 on the power segment
    always_comb
    begin
        for (int j = 1; j <= QUOT_W; j++)
        begin
            div_shift[j] = {div_rem_reg[j-1], 1'b0};
            div_ge[j] = div_shift[j] >= {1'b0, div_pipe_reg[j-1].c0};
            if (div_ge[j])
            begin
                div_rem_next[j] = COUNT_W'(div_shift[j] - {1'b0, div_pipe_reg[j-1].c0});
            end
            else
            begin
                div_rem_next[j] = div_shift[j][COUNT_W-1:0];
            end
        end
    end

    // table lookup with both neighbors, index clamped to the last entry
    always_comb
    begin
        k_raw = div_quot_reg[QUOT_W][QUOT_W-1:POW_FRAC_W];
        k_lo = (k_raw > IDX_W'(POW_ENTRIES)) ? IDX_W'(POW_ENTRIES) : k_raw;
        k_hi = (k_lo == IDX_W'(POW_ENTRIES)) ? k_lo : k_lo + 1'b1;
        tbl_lo = POW_TABLE[k_lo];
        tbl_hi = POW_TABLE[k_hi];
        e1_d_next = (tbl_hi > tbl_lo) ? tbl_hi - tbl_lo : '0;
    end

    always_comb
    begin
        interp_prod = (2*POW_FRAC_W)'(e1_d_reg) * (2*POW_FRAC_W)'(e1_f_reg);
        e2_v_next = e1_lo_reg + interp_prod[2*POW_FRAC_W-1:POW_FRAC_W];
        slope_prod = (COEF_W+1)'(e2_v_reg) * (COEF_W+1)'(POW_SLOPE);
        if ({1'b0, POW_BASE} > slope_prod)
        begin
            e3_coef_next = COEF_W'({1'b0, POW_BASE} - slope_prod);
        end
        else
        begin
            e3_coef_next = '0;
        end
        lux_prod = PROD_W'(e_pipe_reg[3].c0) * PROD_W'(e3_coef_reg);
    end

    // power path is floor(z / 625) = floor(5z / 3125)
    always_comb
    begin
        case (e_pipe_reg[4].seg)
            SEG_POWER:
            begin
                e5_n_next = NUM_W'(e4_z_reg) + (NUM_W'(e4_z_reg) << 2);
            end
            SEG_LIN_LOW, SEG_LIN_MID, SEG_LIN_HIGH:
            begin
                e5_n_next = e_pipe_reg[4].lin_num;
            end
            default:
            begin
                e5_n_next = '0;
            end
        endcase
    end

    always_comb
    begin
        recip_prod = RECIP_PROD_W'(e5_n_reg) * RECIP_PROD_W'(RECIP_MULT);
        qest_prod = (NUM_W+2)'(e6_qest_reg) * (NUM_W+2)'(DIV_CONST);
        rem_wide = (NUM_W+2)'(e6_n_reg) - qest_prod;
        quot_fix = (QEST_W+1)'(e6_qest_reg) +
                   (QEST_W+1)'(rem_wide >= (NUM_W+2)'(DIV_CONST));
        if (quot_fix > (QEST_W+1)'(LUX_MAX))
        begin
            lux_next = LUX_MAX;
        end
        else
        begin
            lux_next = quot_fix[LUX_W-1:0];
        end
        lamp_next = e_pipe_reg[6].motion && (!e_pipe_reg[6].lux_valid || lux_next < dark_bound);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg <= 1'b0;
            for (int j = 0; j <= QUOT_W; j++)
            begin
                div_vld_reg[j] <= 1'b0;
            end
            for (int j = 1; j <= 6; j++)
            begin
                e_vld_reg[j] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            p0_vld_reg <= pop;
            div_vld_reg[0] <= p0_vld_reg;
            for (int j = 1; j <= QUOT_W; j++)
            begin
                div_vld_reg[j] <= div_vld_reg[j-1];
            end
            e_vld_reg[1] <= div_vld_reg[QUOT_W];
            for (int j = 2; j <= 6; j++)
            begin
                e_vld_reg[j] <= e_vld_reg[j-1];
            end
            done_reg <= e_vld_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        p0_job_reg <= rd_job;
        p0_pa_reg <= LIN_PROD_W'(rd_job.item.broadband_count) * LIN_PROD_W'(lin_a);
        p0_pb_reg <= LIN_PROD_W'(rd_job.item.infrared_count) * LIN_PROD_W'(lin_b);

        div_pipe_reg[0] <= d0_pipe_next;
        div_rem_reg[0] <= p0_job_reg.item.infrared_count;
        div_quot_reg[0] <= '0;
        for (int j = 1; j <= QUOT_W; j++)
        begin
            div_pipe_reg[j] <= div_pipe_reg[j-1];
            div_rem_reg[j] <= div_rem_next[j];
            div_quot_reg[j] <= {div_quot_reg[j-1][QUOT_W-2:0], div_ge[j]};
        end

        e_pipe_reg[1] <= div_pipe_reg[QUOT_W];
        for (int j = 2; j <= 6; j++)
        begin
            e_pipe_reg[j] <= e_pipe_reg[j-1];
        end
        e1_lo_reg <= tbl_lo;
        e1_d_reg <= e1_d_next;
        e1_f_reg <= div_quot_reg[QUOT_W][POW_FRAC_W-1:0];
        e2_v_reg <= e2_v_next;
        e3_coef_reg <= e3_coef_next;
        e4_z_reg <= lux_prod[PROD_W-1:PRE_SHIFT];
        e5_n_reg <= e5_n_next;
        e6_n_reg <= e5_n_reg;
        e6_qest_reg <= recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];

        result_reg.lux_value <= lux_next;
        result_reg.lux_valid <= e_pipe_reg[6].lux_valid;
        result_reg.lamp_request <= lamp_next;
    end

    assign done = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop, BACK_LAT))
        else $error("result strobe does not match a drained reading");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.lux_valid) |-> result.lux_value == '0)
        else $error("invalid reading with nonzero lux");
    a_bright_no_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.lux_valid && result.lux_value >= dark_bound) |->
        !result.lamp_request)
        else $error("lamp requested above the dark bound");
`endif

endmodule

// ===== rtl/ambient_light_lux_calc_top.sv =====
// top level of the lux calculator: threshold register, front end, queue, back end
// a reading taken at start comes out with a done strobe and its result;
// one reading per cycle sustained while busy stays low
// the back end holds the 23-stage ratio divider and six arithmetic stages, all pipelined
// busy rises only if the queue fills, which does not happen for QUEUE_DEPTH above one since results cannot stall
// reset (rst_n low, asynchronous) empties the pipeline and queue, dark_bound goes to 25600
module ambient_light_lux_calc_top
#(
    parameter int QUEUE_DEPTH = alc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  alc_pkg::alc_item_t        item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [alc_pkg::LUX_W-1:0] cfg_data,
    output logic                      done,
    output alc_pkg::alc_result_t      result
);
    import alc_pkg::*;

    logic [LUX_W-1:0] dark_bound_reg;
    logic             push;
    logic             pop;
    alc_job_t         wr_job;
    alc_job_t         rd_job;
    alc_qstat_t       qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_bound_reg <= DARK_BOUND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dark_bound_reg <= cfg_data;
        end
    end

    alc_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .qstat  (qstat),
        .busy   (busy),
        .push   (push),
        .wr_job (wr_job)
    );

    alc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .stat   (qstat)
    );

    alc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .rd_job     (rd_job),
        .dark_bound (dark_bound_reg),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule
